### rtl/gradient_noise_3d_defines.svh
// Assertion macros shared by the gradient noise checker
`ifndef GRADIENT_NOISE_3D_DEFINES_SVH
`define GRADIENT_NOISE_3D_DEFINES_SVH

// checked outside reset
`define GN3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in and out of reset
`define GN3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gn3_pkg.sv
// Package: constants, gradient table and types for the 3D gradient noise block
`timescale 1ns / 1ps
package gn3_pkg;

  localparam int COORD_W    = 32;
  localparam int PERM_W     = 8;
  localparam int OUT_W      = 16;
  localparam int NUM_STAGES = 10;

  localparam int RAM_A_BASE = 0;
  localparam int RAM_B_BASE = 2;
  localparam int RAM_C_BASE = 6;
  localparam int NUM_RAMS   = 14;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic signed [1:0] coef_t;

  localparam coef_t C_P = 2'sd1;
  localparam coef_t C_N = -2'sd1;
  localparam coef_t C_Z = 2'sd0;

  typedef struct packed {
    coef_t gx;
    coef_t gy;
    coef_t gz;
  } grad_t;

  function automatic grad_t grad_of(input logic [3:0] h);
    grad_t g;
    case (h)
      4'd0:  g = '{C_P, C_P, C_Z};
      4'd1:  g = '{C_N, C_P, C_Z};
      4'd2:  g = '{C_P, C_N, C_Z};
      4'd3:  g = '{C_N, C_N, C_Z};
      4'd4:  g = '{C_P, C_Z, C_P};
      4'd5:  g = '{C_N, C_Z, C_P};
      4'd6:  g = '{C_P, C_Z, C_N};
      4'd7:  g = '{C_N, C_Z, C_N};
      4'd8:  g = '{C_Z, C_P, C_P};
      4'd9:  g = '{C_Z, C_N, C_P};
      4'd10: g = '{C_Z, C_P, C_N};
      4'd11: g = '{C_Z, C_N, C_N};
      4'd12: g = '{C_P, C_P, C_Z};
      4'd13: g = '{C_N, C_P, C_Z};
      4'd14: g = '{C_Z, C_N, C_P};
      4'd15: g = '{C_Z, C_N, C_N};
      default: g = '{C_Z, C_Z, C_Z};
    endcase
    return g;
  endfunction

endpackage

### rtl/gn3_ram.sv
// Generic single write port RAM with one registered read port
`timescale 1ns / 1ps
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/gradient_noise_3d.sv
// Top level: pipelined 3D improved gradient noise with loadable permutation table
`timescale 1ns / 1ps
// Takes one word per cycle while in_tready is high and returns a noise sample for
// each accepted evaluate word, held while out_tready is low. The permutation
// table is kept in 14 copies, one per hash read, so all hash lookups of one
// word happen in three consecutive stages without sharing a port; a load word
// updates each copy as it passes that copy's read stage, so words always see
// the table as it was when they were accepted. Load words give no result.
// The table holds no defined contents until loaded; TABLE_SIZE must be a
// power of two.
module gradient_noise_3d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [7:0] table_index, [15:8] table_value, [47:16] coord_x,
  // [79:48] coord_y, [111:80] coord_z
  input  logic [111:0]                 in_tdata,
  // [0] mode
  input  logic [0:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [15:0] noise_value
  output logic [gn3_pkg::OUT_W-1:0]    out_tdata
);
  import gn3_pkg::*;

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int F  = FRAC_BITS;
  localparam int OW = F + 1;
  localparam int DW = F + 3;
  localparam int FW = F + 1;
  localparam int PW = 2 * F + 6;

  logic [NUM_STAGES:1] vld_r;
  logic [NUM_STAGES:1] rdy;

  always_comb begin
    rdy[NUM_STAGES] = !vld_r[NUM_STAGES] || out_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[1];

  logic [NUM_STAGES:1] vld_nxt;
  logic                s3_mode_r;

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 1; k <= NUM_STAGES; k++) begin
      if (rdy[k]) begin
        if (k == 1) begin
          vld_nxt[k] = in_tvalid;
        end else if (k == 4) begin
          vld_nxt[k] = vld_r[3] && (s3_mode_r == MODE_EVAL);
        end else begin
          vld_nxt[k] = vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // input field split
  logic              in_mode;
  logic [TW-1:0]     in_idx;
  logic [PERM_W-1:0] in_val;
  logic [COORD_W-1:0] in_coord [3];
  logic [TW-1:0]     in_cell [3];
  logic [F-1:0]      in_frac [3];

  always_comb begin
    in_mode     = in_tuser[0];
    in_idx      = TW'(in_tdata[7:0]);
    in_val      = in_tdata[15:8];
    in_coord[0] = in_tdata[47:16];
    in_coord[1] = in_tdata[79:48];
    in_coord[2] = in_tdata[111:80];
    for (int i = 0; i < 3; i++) begin
      in_cell[i] = TW'($signed(in_coord[i]) >>> F);
      in_frac[i] = in_coord[i][F-1:0];
    end
  end

  // table copies
  logic              ram_we    [NUM_RAMS];
  logic              ram_re    [NUM_RAMS];
  logic [TW-1:0]     ram_waddr [NUM_RAMS];
  logic [PERM_W-1:0] ram_wdata [NUM_RAMS];
  logic [TW-1:0]     ram_raddr [NUM_RAMS];
  logic [PERM_W-1:0] ram_rdata [NUM_RAMS];

  for (genvar g = 0; g < NUM_RAMS; g++) begin : g_ram
    gn3_ram #(
      .WIDTH (PERM_W),
      .DEPTH (TABLE_SIZE)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_we[g]),
      .wr_addr (ram_waddr[g]),
      .wr_data (ram_wdata[g]),
      .rd_en   (ram_re[g]),
      .rd_addr (ram_raddr[g]),
      .rd_data (ram_rdata[g])
    );
  end

  // stage 1
  logic              s1_mode_r;
  logic [TW-1:0]     s1_idx_r;
  logic [PERM_W-1:0] s1_val_r;
  logic [TW-1:0]     s1_y0_r;
  logic [TW-1:0]     s1_z0_r;
  logic [F-1:0]      s1_frac_r [3];
  logic [2*F-1:0]    s1_t2_r   [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_mode_r <= in_mode;
      s1_idx_r  <= in_idx;
      s1_val_r  <= in_val;
      s1_y0_r   <= in_cell[1];
      s1_z0_r   <= in_cell[2];
      for (int i = 0; i < 3; i++) begin
        s1_frac_r[i] <= in_frac[i];
        s1_t2_r[i]   <= in_frac[i] * in_frac[i];
      end
    end
  end

  // stage 2
  logic              s2_mode_r;
  logic [TW-1:0]     s2_idx_r;
  logic [PERM_W-1:0] s2_val_r;
  logic [TW-1:0]     s2_z0_r;
  logic [F-1:0]      s2_frac_r [3];
  logic [F+3:0]      s2_p_r    [3];
  logic [F-1:0]      s2_t3_r   [3];
  logic [2*F+3:0]    fade_num  [3];
  logic [2*F-1:0]    t3_full   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fade_num[i] = ((2*F+4)'(s1_t2_r[i]) << 2) + ((2*F+4)'(s1_t2_r[i]) << 1)
                  + ((2*F+4)'(10) << (2*F))
                  - ((((2*F+4)'(s1_frac_r[i]) << 4) - (2*F+4)'(s1_frac_r[i])) << F);
      t3_full[i]  = s1_t2_r[i][2*F-1:F] * s1_frac_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_mode_r <= s1_mode_r;
      s2_idx_r  <= s1_idx_r;
      s2_val_r  <= s1_val_r;
      s2_z0_r   <= s1_z0_r;
      for (int i = 0; i < 3; i++) begin
        s2_frac_r[i] <= s1_frac_r[i];
        s2_p_r[i]    <= fade_num[i][2*F+3:F];
        s2_t3_r[i]   <= t3_full[i][2*F-1:F];
      end
    end
  end

  // stage 3
  logic [F-1:0]   s3_frac_r [3];
  logic [FW-1:0]  s3_fade_r [3];
  logic [2*F+3:0] fade_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fade_full[i] = s2_t3_r[i] * s2_p_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_mode_r <= s2_mode_r;
      for (int i = 0; i < 3; i++) begin
        s3_frac_r[i] <= s2_frac_r[i];
        s3_fade_r[i] <= fade_full[i][F+FW-1:F];
      end
    end
  end

  // table access per stage
  logic [TW-1:0] hash_a;
  logic [TW-1:0] hash_b;
  logic [TW-1:0] hash_c [4];

  always_comb begin
    hash_a = TW'(ram_rdata[RAM_A_BASE]) + s1_y0_r;
    hash_b = TW'(ram_rdata[RAM_A_BASE+1]) + s1_y0_r;
    for (int j = 0; j < 4; j++) begin
      hash_c[j] = TW'(ram_rdata[RAM_B_BASE+j]) + s2_z0_r;
    end
    for (int g = 0; g < NUM_RAMS; g++) begin
      ram_raddr[g] = '0;
      if (g < RAM_B_BASE) begin
        ram_re[g]    = rdy[1];
        ram_we[g]    = in_tvalid && rdy[1] && (in_mode == MODE_LOAD);
        ram_waddr[g] = in_idx;
        ram_wdata[g] = in_val;
      end else if (g < RAM_C_BASE) begin
        ram_re[g]    = rdy[2];
        ram_we[g]    = vld_r[1] && rdy[2] && (s1_mode_r == MODE_LOAD);
        ram_waddr[g] = s1_idx_r;
        ram_wdata[g] = s1_val_r;
      end else begin
        ram_re[g]    = rdy[3];
        ram_we[g]    = vld_r[2] && rdy[3] && (s2_mode_r == MODE_LOAD);
        ram_waddr[g] = s2_idx_r;
        ram_wdata[g] = s2_val_r;
      end
    end
    ram_raddr[RAM_A_BASE]     = in_cell[0];
    ram_raddr[RAM_A_BASE+1]   = in_cell[0] + TW'(1);
    ram_raddr[RAM_B_BASE]     = hash_a;
    ram_raddr[RAM_B_BASE+1]   = hash_a + TW'(1);
    ram_raddr[RAM_B_BASE+2]   = hash_b;
    ram_raddr[RAM_B_BASE+3]   = hash_b + TW'(1);
    // corners: aa, ba, ab, bb, then the same at z+1
    ram_raddr[RAM_C_BASE]     = hash_c[0];
    ram_raddr[RAM_C_BASE+1]   = hash_c[2];
    ram_raddr[RAM_C_BASE+2]   = hash_c[1];
    ram_raddr[RAM_C_BASE+3]   = hash_c[3];
    ram_raddr[RAM_C_BASE+4]   = hash_c[0] + TW'(1);
    ram_raddr[RAM_C_BASE+5]   = hash_c[2] + TW'(1);
    ram_raddr[RAM_C_BASE+6]   = hash_c[1] + TW'(1);
    ram_raddr[RAM_C_BASE+7]   = hash_c[3] + TW'(1);
  end

  // stage 4: corner dot products
  function automatic logic signed [DW-1:0] axis_term(input coef_t c,
                                                     input logic signed [OW-1:0] o);
    logic signed [DW-1:0] r;
    case (c)
      C_P:     r = DW'(o);
      C_N:     r = -DW'(o);
      default: r = '0;
    endcase
    return r;
  endfunction

  logic signed [DW-1:0] s4_dot_r  [8];
  logic [FW-1:0]        s4_fade_r [3];
  logic signed [DW-1:0] dot       [8];
  logic signed [OW-1:0] offs      [3][2];
  grad_t                grd       [8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offs[i][0] = $signed({1'b0, s3_frac_r[i]});
      offs[i][1] = $signed({1'b1, s3_frac_r[i]});
    end
    for (int c = 0; c < 8; c++) begin
      grd[c] = grad_of(ram_rdata[RAM_C_BASE+c][3:0]);
      dot[c] = axis_term(grd[c].gx, offs[0][c%2])
             + axis_term(grd[c].gy, offs[1][(c/2)%2])
             + axis_term(grd[c].gz, offs[2][c/4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_dot_r  <= dot;
      s4_fade_r <= s3_fade_r;
    end
  end

  // stages 5..9: three lerp levels, product then add; the last add is in stage 10
  logic signed [PW-1:0] s5_prod_r [4];
  logic signed [DW-1:0] s5_base_r [4];
  logic [FW-1:0]        s5_v_r;
  logic [FW-1:0]        s5_w_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int j = 0; j < 4; j++) begin
        s5_prod_r[j] <= PW'($signed({1'b0, s4_fade_r[0]})
                      * ((DW+1)'(s4_dot_r[2*j+1]) - (DW+1)'(s4_dot_r[2*j])));
        s5_base_r[j] <= s4_dot_r[2*j];
      end
      s5_v_r <= s4_fade_r[1];
      s5_w_r <= s4_fade_r[2];
    end
  end

  logic signed [DW-1:0] s6_l_r [4];
  logic [FW-1:0]        s6_v_r;
  logic [FW-1:0]        s6_w_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int j = 0; j < 4; j++) begin
        s6_l_r[j] <= s5_base_r[j] + DW'(s5_prod_r[j] >>> F);
      end
      s6_v_r <= s5_v_r;
      s6_w_r <= s5_w_r;
    end
  end

  logic signed [PW-1:0] s7_prod_r [2];
  logic signed [DW-1:0] s7_base_r [2];
  logic [FW-1:0]        s7_w_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int j = 0; j < 2; j++) begin
        s7_prod_r[j] <= PW'($signed({1'b0, s6_v_r})
                      * ((DW+1)'(s6_l_r[2*j+1]) - (DW+1)'(s6_l_r[2*j])));
        s7_base_r[j] <= s6_l_r[2*j];
      end
      s7_w_r <= s6_w_r;
    end
  end

  logic signed [DW-1:0] s8_l_r [2];
  logic [FW-1:0]        s8_w_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int j = 0; j < 2; j++) begin
        s8_l_r[j] <= s7_base_r[j] + DW'(s7_prod_r[j] >>> F);
      end
      s8_w_r <= s7_w_r;
    end
  end

  logic signed [PW-1:0] s9_prod_r;
  logic signed [DW-1:0] s9_base_r;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_prod_r <= PW'($signed({1'b0, s8_w_r})
                 * ((DW+1)'(s8_l_r[1]) - (DW+1)'(s8_l_r[0])));
      s9_base_r <= s8_l_r[0];
    end
  end

  // stage 10: map to [0,1] and clamp
  logic signed [DW-1:0] noise_r;
  logic signed [DW:0]   noise_off;
  logic [DW-1:0]        noise_pos;
  logic [DW+14:0]       noise_sh;
  logic [OUT_W-1:0]     out_data_nxt;
  logic [OUT_W-1:0]     out_data_r;

  always_comb begin
    noise_r   = s9_base_r + DW'(s9_prod_r >>> F);
    noise_off = (DW+1)'(noise_r) + ((DW+1)'(1) << F);
    noise_pos = noise_off[DW] ? '0 : noise_off[DW-1:0];
    noise_sh  = {noise_pos, 15'b0} >> F;
    out_data_nxt = (|noise_sh[DW+14:OUT_W]) ? '1 : noise_sh[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES];
  assign out_tdata  = out_data_r;

endmodule

### rtl/gn3_checker.sv
// Port-level checker for the gradient noise block, bound to the top level
`timescale 1ns / 1ps
`include "gradient_noise_3d_defines.svh"
module gn3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [gn3_pkg::OUT_W-1:0] out_tdata
);
  import gn3_pkg::*;

  `GN3_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `GN3_ASSERT(a_ready_pass, out_tready |-> in_tready, "input stalled while output drains")
  `GN3_ASSERT(a_ready_empty, !out_tvalid |-> in_tready, "input stalled with empty output")
  `GN3_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result word after reset")

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
